@@ sv/bavg_pkg.sv @@
// Shared types and constants for the box-average downscaler.
package bavg_pkg;

	// Fixed field and register widths
	localparam int CH_W = 8;
	localparam int NCH = 4;
	localparam int SF_W = 5;
	localparam int SW_W = 11;
	localparam int SH_W = 13;
	localparam int CC_W = 3;
	localparam int COL_W = 10;
	localparam int ROW_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam int S_TDATA_W = NCH * CH_W;
	localparam int M_TDATA_W = 56;
	localparam int DVS_W = 2 * SF_W;
	localparam int NLANE = NCH + 1;
	localparam int H_MAX = 4096;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANS = 2'd3;
	localparam logic [CC_W-1:0] CHANS_FOUR = 3'd4;

	typedef logic [NCH-1:0][CH_W-1:0] pix_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic clr_step;
		logic add;
		logic setup_load;
		logic div_step;
		logic setup_fin;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic cfg_dirty;
		logic sums_dirty;
		logic clr_last;
		logic emit;
		logic out_free;
	} sts_t;

endpackage

@@ sv/bavg_div.sv @@
// One lane of a restoring divider, one quotient bit per step.
module bavg_div #(
	parameter int DIV_W = 16,
	parameter int DVS_W = 10
) (
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DIV_W-1:0] quo
);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	// Shift the next dividend bit into the partial remainder
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (step) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign quo = quo_q;

endmodule

@@ sv/bavg_dp.sv @@
// Datapath: config registers, raster counters, column sum memory, dividers, output word.
module bavg_dp #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_FACTOR = 16,
	parameter int DIV_W = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [bavg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bavg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  bavg_pkg::pix_t                pix,
	input  logic                          frame_start,
	input  bavg_pkg::cmd_t                cmd,
	output bavg_pkg::sts_t                sts,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bavg_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int BW = (MAX_FACTOR > 2) ? $clog2(MAX_FACTOR) : 1;
	localparam int SW = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
	localparam int NLIM = (MAX_FACTOR > 31) ? 31 : MAX_FACTOR;
	localparam int WLIM = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
	localparam int SF_W = bavg_pkg::SF_W;
	localparam int SW_W = bavg_pkg::SW_W;
	localparam int SH_W = bavg_pkg::SH_W;
	localparam int NCH = bavg_pkg::NCH;
	localparam int NLANE = bavg_pkg::NLANE;
	localparam int DVS_W = bavg_pkg::DVS_W;
	localparam int CH_W = bavg_pkg::CH_W;

	// Configuration registers
	logic [SF_W-1:0]           sf_q;
	logic [SW_W-1:0]           sw_q;
	logic [SH_W-1:0]           sh_q;
	logic [bavg_pkg::CC_W-1:0] cc_q;
	logic                      cfg_dirty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q <= SF_W'(1);
			sw_q <= SW_W'(1024);
			sh_q <= SH_W'(1024);
			cc_q <= bavg_pkg::CHANS_FOUR;
			cfg_dirty_q <= 1'b1;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					bavg_pkg::REG_SCALE:  sf_q <= cfg_wdata[SF_W-1:0];
					bavg_pkg::REG_WIDTH:  sw_q <= cfg_wdata[SW_W-1:0];
					bavg_pkg::REG_HEIGHT: sh_q <= cfg_wdata[SH_W-1:0];
					bavg_pkg::REG_CHANS:  cc_q <= cfg_wdata[bavg_pkg::CC_W-1:0];
					default: ;
				endcase
			end
			if (cfg_wen)
				cfg_dirty_q <= 1'b1;
			else if (cmd.setup_load)
				cfg_dirty_q <= 1'b0;
		end
	end

	// Clamped settings
	logic [SF_W-1:0]  n;
	logic [SW_W-1:0]  w;
	logic [SH_W-1:0]  h;
	logic             four;
	logic [DVS_W-1:0] n_sq;

	always_comb begin
		if (sf_q == '0)
			n = SF_W'(1);
		else if (sf_q > SF_W'(NLIM))
			n = SF_W'(NLIM);
		else
			n = sf_q;
		if (sw_q == '0)
			w = SW_W'(1);
		else if (sw_q > SW_W'(WLIM))
			w = SW_W'(WLIM);
		else
			w = sw_q;
		if (sh_q == '0)
			h = SH_W'(1);
		else if (sh_q > SH_W'(bavg_pkg::H_MAX))
			h = SH_W'(bavg_pkg::H_MAX);
		else
			h = sh_q;
	end

	assign four = cc_q == bavg_pkg::CHANS_FOUR;
	assign n_sq = DVS_W'(n) * DVS_W'(n);

	// Whole-block area, refreshed by the setup pass
	logic [SW_W-1:0]  whole_w_q;
	logic [SH_W-1:0]  whole_h_q;
	logic [DIV_W-1:0] quo [NLANE];

	always_ff @(posedge clk) begin
		if (cmd.setup_fin) begin
			whole_w_q <= SW_W'(quo[0] * DIV_W'(n));
			whole_h_q <= SH_W'(quo[1] * DIV_W'(n));
		end
	end

	// Raster counters
	logic [CW-1:0]                  sc_q;
	logic [bavg_pkg::ROW_W-1:0]     sr_q;
	logic [BW-1:0]                  rib_q;
	logic [BW-1:0]                  cib_q;
	logic [CW-1:0]                  dc_q;
	logic                           in_area;
	logic                           emit;
	logic                           col_wrap;
	logic                           row_end;
	logic                           rib_wrap;
	logic                           sr_wrap;
	logic [31:0]                    cib_inc;
	logic [31:0]                    sc_inc;
	logic [31:0]                    rib_inc;
	logic [31:0]                    sr_inc;

	always_comb begin
		in_area  = (32'(sc_q) < 32'(whole_w_q)) && (32'(sr_q) < 32'(whole_h_q));
		emit     = in_area && (32'(cib_q) == 32'(n) - 32'd1) &&
			(32'(rib_q) == 32'(n) - 32'd1);
		cib_inc  = 32'(cib_q) + 32'd1;
		sc_inc   = 32'(sc_q) + 32'd1;
		rib_inc  = 32'(rib_q) + 32'd1;
		sr_inc   = 32'(sr_q) + 32'd1;
		col_wrap = cib_inc >= 32'(n);
		row_end  = sc_inc >= 32'(w);
		rib_wrap = rib_inc >= 32'(n);
		sr_wrap  = sr_inc >= 32'(h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= '0;
			sr_q <= '0;
			rib_q <= '0;
			cib_q <= '0;
			dc_q <= '0;
		end else if (cmd.accept && frame_start) begin
			sc_q <= '0;
			sr_q <= '0;
			rib_q <= '0;
			cib_q <= '0;
			dc_q <= '0;
		end else if (cmd.add) begin
			if (row_end) begin
				sc_q <= '0;
				cib_q <= '0;
				dc_q <= '0;
				rib_q <= (rib_wrap || sr_wrap) ? '0 : BW'(rib_inc);
				sr_q <= sr_wrap ? '0 : bavg_pkg::ROW_W'(sr_inc);
			end else begin
				sc_q <= CW'(sc_inc);
				cib_q <= col_wrap ? '0 : BW'(cib_inc);
				dc_q <= col_wrap ? CW'(32'(dc_q) + 32'd1) : dc_q;
			end
		end
	end

	// Pixel held for the accumulate step
	bavg_pkg::pix_t pix_q;

	always_ff @(posedge clk) begin
		if (cmd.accept)
			pix_q <= pix;
	end

	// Clearing sweep covers columns up to the highest one touched
	logic [CW-1:0] clr_addr_q;
	logic [CW-1:0] hwm_q;
	logic          dirty_q;
	logic          clr_last;

	assign clr_last = clr_addr_q == hwm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			hwm_q <= CW'(MAX_WIDTH - 1);
			dirty_q <= 1'b1;
		end else if (cmd.clr_step) begin
			if (clr_last) begin
				clr_addr_q <= '0;
				hwm_q <= '0;
				dirty_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + CW'(1);
			end
		end else if (cmd.add && in_area) begin
			dirty_q <= 1'b1;
			if (!dirty_q || dc_q > hwm_q)
				hwm_q <= dc_q;
		end
	end

	// Column sum memory, four channel sums per destination column
	logic [NCH*SW-1:0] sum_mem [MAX_WIDTH];
	logic [NCH*SW-1:0] rd_q;
	logic [NCH*SW-1:0] new_sum;
	logic              wr_en;
	logic [CW-1:0]     wr_addr;
	logic [NCH*SW-1:0] wr_data;

	always_comb begin
		for (int k = 0; k < NCH; k++) begin
			new_sum[k*SW +: SW] = rd_q[k*SW +: SW] +
				((k < 3 || four) ? SW'(pix_q[k]) : SW'(0));
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = dc_q;
		wr_data = '0;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
			wr_addr = clr_addr_q;
		end else if (cmd.add && in_area) begin
			wr_en = 1'b1;
			wr_data = emit ? '0 : new_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			sum_mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		rd_q <= sum_mem[dc_q];
	end

	// Divider lanes: four channel sums by n*n and the row by n;
	// the setup pass reuses lanes 0 and 1 for width and height by n
	logic                          div_load;
	logic [DIV_W-1:0]              dividend [NLANE];
	logic [DVS_W-1:0]              divisor [NLANE];

	assign div_load = cmd.setup_load || (cmd.add && emit);

	always_comb begin
		for (int k = 0; k < NLANE; k++) begin
			if (k < NCH)
				dividend[k] = DIV_W'(new_sum[k*SW +: SW]);
			else
				dividend[k] = DIV_W'(sr_q);
			divisor[k] = (k < NCH) ? n_sq : DVS_W'(n);
		end
		if (cmd.setup_load) begin
			dividend[0] = DIV_W'(w);
			dividend[1] = DIV_W'(h);
			divisor[0] = DVS_W'(n);
			divisor[1] = DVS_W'(n);
		end
	end

	for (genvar g = 0; g < NLANE; g++) begin : g_lane
		bavg_div #(
			.DIV_W(DIV_W),
			.DVS_W(DVS_W)
		) u_div (
			.clk      (clk),
			.load     (div_load),
			.step     (cmd.div_step),
			.dividend (dividend[g]),
			.divisor  (divisor[g]),
			.quo      (quo[g])
		);
	end

	// Details of the pending output word
	logic [CW-1:0] em_col_q;
	logic          em_fe_q;
	logic          em_four_q;

	always_ff @(posedge clk) begin
		if (cmd.add && emit) begin
			em_col_q <= dc_q;
			em_fe_q <= (32'(sc_q) == 32'(whole_w_q) - 32'd1) &&
				(32'(sr_q) == 32'(whole_h_q) - 32'd1);
			em_four_q <= four;
		end
	end

	// Output register
	logic                           m_tvalid_q;
	logic [NCH-1:0][CH_W-1:0]       avg_q;
	logic [bavg_pkg::COL_W-1:0]     col_q;
	logic [bavg_pkg::ROW_W-1:0]     row_q;
	logic                           last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			for (int k = 0; k < NCH; k++)
				avg_q[k] <= (k < 3 || em_four_q) ? quo[k][CH_W-1:0] : '0;
			col_q <= bavg_pkg::COL_W'(em_col_q);
			row_q <= quo[NCH][bavg_pkg::ROW_W-1:0];
			last_q <= em_fe_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, row_q, col_q, avg_q};
	assign m_tlast  = last_q;

	assign sts.cfg_dirty  = cfg_dirty_q;
	assign sts.sums_dirty = dirty_q;
	assign sts.clr_last   = clr_last;
	assign sts.emit       = emit;
	assign sts.out_free   = !m_tvalid_q || m_tready;

	// A word is only loaded into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("output word overwritten before taken");

	// Finishing a sweep leaves the memory marked clean
	a_sweep_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clr_step && clr_last) |=> !dirty_q)
		else $error("sum memory still dirty after sweep");

endmodule

@@ sv/bavg_ctrl.sv @@
// Controller: sequences clearing sweeps, setup, accumulate and divide steps.
module bavg_ctrl #(
	parameter int DIV_W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic           frame_start,
	input  bavg_pkg::sts_t sts,
	output logic           s_tready,
	output bavg_pkg::cmd_t cmd
);

	localparam int CNT_W = $clog2(DIV_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_FCLR = 4'd2;
	localparam logic [3:0] ST_RD   = 4'd3;
	localparam logic [3:0] ST_ADD  = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_OUT  = 4'd6;
	localparam logic [3:0] ST_SDIV = 4'd7;
	localparam logic [3:0] ST_SFIN = 4'd8;

	logic [3:0]       state_q;
	logic [3:0]       state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;

	assign s_tready = (state_q == ST_IDLE) && !sts.cfg_dirty;
	assign accept   = s_tvalid && s_tready;

	// Next state and commands
	always_comb begin
		cmd = '0;
		cmd.accept = accept;
		state_nx = state_q;
		case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (sts.cfg_dirty) begin
					cmd.setup_load = 1'b1;
					state_nx = ST_SDIV;
				end else if (accept) begin
					if (frame_start)
						state_nx = sts.sums_dirty ? ST_FCLR : ST_RD;
					else
						state_nx = ST_ADD;
				end
			end
			ST_FCLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_nx = ST_RD;
			end
			ST_RD: state_nx = ST_ADD;
			ST_ADD: begin
				cmd.add = 1'b1;
				state_nx = sts.emit ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST)
					state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_SDIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST)
					state_nx = ST_SFIN;
			end
			ST_SFIN: begin
				cmd.setup_fin = 1'b1;
				state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (cmd.div_step)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
		end
	end

	// One word in flight: after taking a word the controller is busy
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("second word taken while one is in flight");

	// Accumulate follows directly on accept or on the re-read
	a_add_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_RD))
		else $error("accumulate step without a fresh memory read");

endmodule

@@ sv/box_average_downscale.sv @@
// Box-average downscaler top level: N by N block averages of a raster pixel stream.
// Each pixel is taken, then accumulated, before the next is taken; one that closes a block
// also runs DIV_W quotient steps (16 at defaults) plus any wait for the output register.
// The block's word is registered at the output once its division is done. Frame start adds
// a sweep up to the highest column written since the last one, then a re-read of the sum;
// config writes start a setup pass. Reset sweeps MAX_WIDTH columns, then sets up.
module box_average_downscale #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_FACTOR = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [bavg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bavg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// chan_zero, chan_one, chan_two, chan_three
	input  logic [bavg_pkg::S_TDATA_W-1:0]  s_tdata,
	// frame_start
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// avg_zero, avg_one, avg_two, avg_three, out_column, out_row, zero fill
	output logic [bavg_pkg::M_TDATA_W-1:0]  m_tdata,
	// frame_end
	output logic                            m_tlast
);

	localparam int SUM_W = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
	localparam int DIV_W = (SUM_W > bavg_pkg::SH_W) ? SUM_W : bavg_pkg::SH_W;

	bavg_pkg::cmd_t cmd;
	bavg_pkg::sts_t sts;

	bavg_ctrl #(
		.DIV_W(DIV_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.frame_start (s_tuser),
		.sts         (sts),
		.s_tready    (s_tready),
		.cmd         (cmd)
	);

	bavg_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR),
		.DIV_W      (DIV_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.pix         (bavg_pkg::pix_t'(s_tdata)),
		.frame_start (s_tuser),
		.cmd         (cmd),
		.sts         (sts),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule

@@ verif/bavg_checker.sv @@
// Scoreboard for the box-average downscaler: tracks register writes, predicts block averages, checks output words.
module bavg_checker #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_FACTOR = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [bavg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bavg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// chan_zero, chan_one, chan_two, chan_three
	input  logic [bavg_pkg::S_TDATA_W-1:0]  s_tdata,
	// frame_start
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// avg_zero, avg_one, avg_two, avg_three, out_column, out_row, zero fill
	input  logic [bavg_pkg::M_TDATA_W-1:0]  m_tdata,
	// frame_end
	input  logic                            m_tlast,
	output int                              fail_count,
	output int                              pending
);
	import bavg_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0]  avg_zero;
		logic [CH_W-1:0]  avg_one;
		logic [CH_W-1:0]  avg_two;
		logic [CH_W-1:0]  avg_three;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             frame_end;
	} block_avg_t;

	// Averages still owed by the block, oldest first
	block_avg_t avg_queue[$];

	// Register copies
	logic [SF_W-1:0] scale_reg;
	logic [SW_W-1:0] width_reg;
	logic [SH_W-1:0] height_reg;
	logic [CC_W-1:0] chans_reg;

	// Per-column channel sums and raster position
	logic [NCH-1:0][31:0] col_sums [MAX_WIDTH];
	int unsigned src_col, src_row, blk_row, blk_col, dst_col;
	int errors;

	// Zero reads as one, large values saturate
	function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic clear_frame();
		for (int i = 0; i < MAX_WIDTH; i++)
			col_sums[i] = '0;
		src_col = 0;
		src_row = 0;
		blk_row = 0;
		blk_col = 0;
		dst_col = 0;
	endtask

	task automatic report(string msg);
		$display("%0t: mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// One source pixel: accumulate, and close a block when its corner arrives
	task automatic take_pixel(input pix_t px, input logic fs);
		int unsigned n, w, h, nch, whole_w, whole_h, div;
		block_avg_t res;
		n = clamp_reg(scale_reg, MAX_FACTOR);
		w = clamp_reg(width_reg, MAX_WIDTH);
		h = clamp_reg(height_reg, H_MAX);
		nch = (chans_reg == CHANS_FOUR) ? 4 : 3;
		whole_w = (w / n) * n;
		whole_h = (h / n) * n;
		if (fs)
			clear_frame();
		if (src_col < whole_w && src_row < whole_h && dst_col < MAX_WIDTH) begin
			for (int k = 0; k < nch; k++)
				col_sums[dst_col][k] = col_sums[dst_col][k] + 32'(px[k]);
			if (blk_col == n - 1 && blk_row == n - 1) begin
				div = n * n;
				res.avg_zero = CH_W'(col_sums[dst_col][0] / div);
				res.avg_one = CH_W'(col_sums[dst_col][1] / div);
				res.avg_two = CH_W'(col_sums[dst_col][2] / div);
				res.avg_three = (nch == 4) ? CH_W'(col_sums[dst_col][3] / div) : '0;
				res.column = COL_W'(dst_col);
				res.row = ROW_W'(src_row / n);
				res.frame_end = (src_col == whole_w - 1 && src_row == whole_h - 1);
				col_sums[dst_col] = '0;
				avg_queue.push_back(res);
			end
		end
		// advance raster position, wrapping at row and frame ends
		blk_col++;
		if (blk_col >= n) begin
			blk_col = 0;
			dst_col++;
		end
		src_col++;
		if (src_col >= w) begin
			src_col = 0;
			blk_col = 0;
			dst_col = 0;
			blk_row++;
			if (blk_row >= n)
				blk_row = 0;
			src_row++;
			if (src_row >= h) begin
				src_row = 0;
				blk_row = 0;
			end
		end
	endtask

	task automatic check_word();
		block_avg_t want;
		if (avg_queue.size() == 0) begin
			report($sformatf("output word with nothing pending, column %0d row %0d",
				m_tdata[4*CH_W +: COL_W], m_tdata[4*CH_W+COL_W +: ROW_W]));
		end else begin
			want = avg_queue.pop_front();
			check_field("avg_zero", m_tdata[0*CH_W +: CH_W], want.avg_zero);
			check_field("avg_one", m_tdata[1*CH_W +: CH_W], want.avg_one);
			check_field("avg_two", m_tdata[2*CH_W +: CH_W], want.avg_two);
			check_field("avg_three", m_tdata[3*CH_W +: CH_W], want.avg_three);
			check_field("out_column", m_tdata[4*CH_W +: COL_W], want.column);
			check_field("out_row", m_tdata[4*CH_W+COL_W +: ROW_W], want.row);
			check_field("frame_end", m_tlast, want.frame_end);
		end
	endtask

	// Watch both streams and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_reg = SF_W'(1);
			width_reg = SW_W'(1024);
			height_reg = SH_W'(1024);
			chans_reg = CHANS_FOUR;
			clear_frame();
			avg_queue.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_word();
			if (cfg_wen) begin
				case (cfg_index)
					REG_SCALE: scale_reg = cfg_wdata[SF_W-1:0];
					REG_WIDTH: width_reg = cfg_wdata[SW_W-1:0];
					REG_HEIGHT: height_reg = cfg_wdata[SH_W-1:0];
					REG_CHANS: chans_reg = cfg_wdata[CC_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_pixel(pix_t'(s_tdata), s_tuser);
			fail_count <= errors;
			pending <= avg_queue.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
// Testbench top for the box-average downscaler: clock, reset, register setup, pixel stimulus, verdict.
module testbench;
	import bavg_pkg::*;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_FACTOR = 16;
	localparam int SETTLE_CYCLES = 1300;   // outlasts the sum sweep after reset or a frame start
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_PHASES = 12;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tlast;
	int                    fail_count;
	int                    pending;
	int                    send_idle_pct = 35;
	int                    recv_idle_pct = 59;
	int                    quiet_cycles = 0;

	always #2 clk = ~clk;

	box_average_downscale #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_FACTOR(MAX_FACTOR)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	bavg_checker #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_FACTOR(MAX_FACTOR)
	) scoreboard (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending)
	);

	// Receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: too long without any word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [S_TDATA_W-1:0] random_pixel();
		pix_t px;
		for (int k = 0; k < NCH; k++) begin
			case ($urandom_range(9))
				0: px[k] = '0;
				1: px[k] = '1;
				default: px[k] = CH_W'($urandom);
			endcase
		end
		return px;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		@(posedge clk);
	endtask

	task automatic setup(input int unsigned scale, width, height, chans);
		write_reg(REG_SCALE, scale);
		write_reg(REG_WIDTH, width);
		write_reg(REG_HEIGHT, height);
		write_reg(REG_CHANS, chans);
		cfg_wen <= 1'b0;
	endtask

	// Hold off until every block average is out and the block has gone quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [S_TDATA_W-1:0] data, input logic fs);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= fs;
		do @(posedge clk); while (!s_tready);
	endtask

	// One register setting followed by a run of pixels
	task automatic run_phase(input int p);
		int unsigned n, w, h, c, neff, frame_px, budget, left, r;
		bit noisy, carry_on;
		logic fs;
		noisy = 1'b0;
		carry_on = 1'b0;
		r = $urandom_range(99);
		c = (r < 45) ? CHANS_FOUR : (r < 85) ? 3 : $urandom_range(0, 7);
		case (p)
			1: begin
				// largest block edge, one whole block
				n = $urandom_range(1) ? 16 : $urandom_range(17, 31);
				w = $urandom_range(16, 19);
				h = 16;
				budget = 320;
			end
			3: begin
				// zero sizes act as one pixel frames
				n = 1;
				w = 0;
				h = 0;
				budget = 50;
			end
			5: begin
				n = 1;
				w = $urandom_range(1) ? 1024 : $urandom_range(1025, 2047);
				h = $urandom_range(1, 3);
				budget = 300;
			end
			9: begin
				n = 1;
				w = 1;
				h = $urandom_range(1) ? 4096 : $urandom_range(4097, 8191);
				budget = 200;
			end
			default: begin
				r = $urandom_range(99);
				n = (r < 20) ? 1 : (r < 60) ? $urandom_range(2, 4) :
					(r < 70) ? $urandom_range(5, 8) : (r < 78) ? 0 :
					(r < 88) ? 16 : $urandom_range(17, 31);
				neff = clamp_size(n, MAX_FACTOR);
				r = $urandom_range(99);
				w = (r < 85) ? neff * $urandom_range(1, 4) + $urandom_range(0, neff - 1) :
					(r < 90) ? 0 : (r < 95) ? 1024 : $urandom_range(1025, 2047);
				r = $urandom_range(99);
				h = (r < 85) ? neff * $urandom_range(1, 3) + $urandom_range(0, neff - 1) :
					(r < 90) ? 0 : (r < 95) ? 4096 : $urandom_range(4097, 8191);
				noisy = ($urandom_range(99) < 15);
				carry_on = ($urandom_range(99) < 20);
				budget = 120;
			end
		endcase
		// upper write data bits beyond a register's width are don't-care
		if ($urandom_range(9) == 0)
			n = n | ($urandom_range(1, 255) << SF_W);
		if ($urandom_range(9) == 0)
			c = c | ($urandom_range(1, 1023) << CC_W);
		setup(n, w, h, c);
		frame_px = clamp_size(w, MAX_WIDTH) * clamp_size(h, H_MAX);
		left = 0;
		for (int i = 0; i < budget; i++) begin
			fs = 1'b0;
			if (noisy) begin
				fs = ($urandom_range(99) < 3);
			end else begin
				if (left == 0) begin
					fs = !(i == 0 && carry_on);
					left = frame_px;
				end
				left--;
			end
			send_pixel(random_pixel(), fs);
		end
	endtask

	initial begin
		logic [S_TDATA_W-1:0] data;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// post-reset sweep of the sum memory
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Directed: odd sizes drop the last column and row, full-scale and zero channels
		setup(2, 5, 3, CHANS_FOUR);
		for (int k = 0; k < 15; k++) begin
			case (k % 3)
				0: data = '1;
				1: data = '0;
				default: data = {NCH{CH_W'(k * 37)}};
			endcase
			send_pixel(data, k == 0);
		end
		settle();

		// Directed: zero scale acts as one, three channels, frame overrun, frame start mid-frame
		setup(0, 2, 1, 3);
		send_pixel('1, 1'b1);
		send_pixel(32'h0102_0304, 1'b0);
		send_pixel('1, 1'b0);
		send_pixel(32'hA55A_C33C, 1'b1);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == RANDOM_PHASES / 3) begin
				send_idle_pct = 59;
				recv_idle_pct = 35;
			end else if (p == 2 * RANDOM_PHASES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			run_phase(p);
			settle();
		end

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/bavg_pkg.sv
sv/bavg_div.sv
sv/bavg_dp.sv
sv/bavg_ctrl.sv
sv/box_average_downscale.sv
verif/bavg_checker.sv
verif/testbench.sv
